// File: rtl/core/swcsf_pkg.sv
// ----------------------------------------------------------------------------
// Sliding-window class score fusion package
// Shared widths, item types, datapath operation codes and status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package swcsf_pkg;

    localparam int SCORE_BITS       = 16;
    localparam int MAX_CLASSES_DEF  = 32;
    localparam int WINDOW_DEPTH_DEF = 1024;
    localparam int CFG_W            = 11;
    localparam int CLASS_OUT_W      = 5;
    localparam int FRAMES_OUT_W     = 11;
    localparam logic [CFG_W-1:0] WINDOW_SIZE_RST = 11'd30;

    typedef struct packed {
        logic signed [SCORE_BITS-1:0] score;
        logic                         last_in_frame;
        logic                         clear_window;
    } t_in_item;

    typedef struct packed {
        logic [CLASS_OUT_W-1:0]  top_class;
        logic                    unknown;
        logic [FRAMES_OUT_W-1:0] frames_held;
        logic                    too_many_classes;
    } t_out_item;

    typedef logic [3:0] t_op;

    localparam t_op OP_NONE   = 4'd0;
    localparam t_op OP_TAKE   = 4'd1;
    localparam t_op OP_CLEAR  = 4'd2;
    localparam t_op OP_CHECK  = 4'd3;
    localparam t_op OP_EV_RD  = 4'd4;
    localparam t_op OP_EV_WR  = 4'd5;
    localparam t_op OP_EW_RD  = 4'd6;
    localparam t_op OP_EW_RD2 = 4'd7;
    localparam t_op OP_EW_WR  = 4'd8;
    localparam t_op OP_ADD_RD = 4'd9;
    localparam t_op OP_ADD_WR = 4'd10;
    localparam t_op OP_WIN_RD = 4'd11;
    localparam t_op OP_WIN_WR = 4'd12;
    localparam t_op OP_ARG_RD = 4'd13;
    localparam t_op OP_ARG_WR = 4'd14;
    localparam t_op OP_OUT    = 4'd15;

    typedef struct packed {
        logic need_evict;
        logic evict_last;
        logic class_last;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// File: rtl/core/swcsf_ctrl.sv
// ----------------------------------------------------------------------------
// Sliding-window class score fusion controller
// Sequences item intake, window eviction, frame insertion and the argmax walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swcsf_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire swcsf_pkg::t_in_item i_in_item,
    output logic                   o_in_stall,
    input  wire swcsf_pkg::t_status i_status,
    output swcsf_pkg::t_op         o_op
);
    import swcsf_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CHECK   = 4'd1;
    localparam logic [3:0] S_EV_TEST = 4'd2;
    localparam logic [3:0] S_EV_RD   = 4'd3;
    localparam logic [3:0] S_EV_WR   = 4'd4;
    localparam logic [3:0] S_EW_RD   = 4'd5;
    localparam logic [3:0] S_EW_RD2  = 4'd6;
    localparam logic [3:0] S_EW_WR   = 4'd7;
    localparam logic [3:0] S_ADD_RD  = 4'd8;
    localparam logic [3:0] S_ADD_WR  = 4'd9;
    localparam logic [3:0] S_WIN_RD  = 4'd10;
    localparam logic [3:0] S_WIN_WR  = 4'd11;
    localparam logic [3:0] S_ARG_RD  = 4'd12;
    localparam logic [3:0] S_ARG_WR  = 4'd13;
    localparam logic [3:0] S_OUT     = 4'd14;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       w_accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_op    = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in_item.clear_window) begin
                        o_op = OP_CLEAR;
                    end else begin
                        o_op = OP_TAKE;
                        if (i_in_item.last_in_frame) begin
                            n_state = S_CHECK;
                        end
                    end
                end
            end
            S_CHECK: begin
                o_op    = OP_CHECK;
                n_state = S_EV_TEST;
            end
            S_EV_TEST: begin
                n_state = i_status.need_evict ? S_EV_RD : S_ADD_RD;
            end
            S_EV_RD: begin
                o_op    = OP_EV_RD;
                n_state = S_EV_WR;
            end
            S_EV_WR: begin
                o_op    = OP_EV_WR;
                n_state = i_status.evict_last ? S_EW_RD : S_EV_RD;
            end
            S_EW_RD: begin
                o_op    = OP_EW_RD;
                n_state = S_EW_RD2;
            end
            S_EW_RD2: begin
                o_op    = OP_EW_RD2;
                n_state = S_EW_WR;
            end
            S_EW_WR: begin
                o_op    = OP_EW_WR;
                n_state = S_EV_TEST;
            end
            S_ADD_RD: begin
                o_op    = OP_ADD_RD;
                n_state = S_ADD_WR;
            end
            S_ADD_WR: begin
                o_op    = OP_ADD_WR;
                n_state = i_status.class_last ? S_WIN_RD : S_ADD_RD;
            end
            S_WIN_RD: begin
                o_op    = OP_WIN_RD;
                n_state = S_WIN_WR;
            end
            S_WIN_WR: begin
                o_op    = OP_WIN_WR;
                n_state = S_ARG_RD;
            end
            S_ARG_RD: begin
                o_op    = OP_ARG_RD;
                n_state = S_ARG_WR;
            end
            S_ARG_WR: begin
                o_op    = OP_ARG_WR;
                n_state = i_status.class_last ? S_OUT : S_ARG_RD;
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_op    = OP_OUT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/swcsf_datapath.sv
// ----------------------------------------------------------------------------
// Sliding-window class score fusion datapath
// Window score and winner memories, per-class sum and win memory, argmax.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swcsf_datapath #(
    parameter int MAX_CLASSES  = swcsf_pkg::MAX_CLASSES_DEF,
    parameter int WINDOW_DEPTH = swcsf_pkg::WINDOW_DEPTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire swcsf_pkg::t_in_item      i_in_item,
    input  wire logic                     i_cfg_valid,
    input  wire logic [swcsf_pkg::CFG_W-1:0] i_cfg_data,
    input  wire swcsf_pkg::t_op           i_op,
    output swcsf_pkg::t_status            o_status,
    input  wire logic                     i_out_stall,
    output logic                          o_out_valid,
    output swcsf_pkg::t_out_item          o_out_item
);
    import swcsf_pkg::*;

    localparam int CIX_W   = $clog2(MAX_CLASSES);
    localparam int CLS_W   = $clog2(MAX_CLASSES + 1);
    localparam int SLOT_W  = $clog2(WINDOW_DEPTH);
    localparam int FRM_W   = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W   = SCORE_BITS + $clog2(WINDOW_DEPTH) + 1;
    localparam int SC_DEPTH = WINDOW_DEPTH * (2 ** CIX_W);

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [FRM_W-1:0]        wins;
    } t_cls;

    logic signed [SCORE_BITS-1:0] m_score [SC_DEPTH];
    logic [CIX_W-1:0]             m_winner [WINDOW_DEPTH];
    logic signed [SCORE_BITS-1:0] m_pend [MAX_CLASSES];
    t_cls                         m_cls [MAX_CLASSES];

    logic [CFG_W-1:0]             r_win_size;
    logic [FRM_W-1:0]             r_frames;
    logic [SLOT_W-1:0]            r_oldest;
    logic [CLS_W-1:0]             r_cpf;
    logic [CLS_W-1:0]             r_ei;
    logic signed [SCORE_BITS-1:0] r_best_score;
    logic [CIX_W-1:0]             r_best_cls;
    logic                         r_ovf;
    logic [CIX_W-1:0]             r_c;
    logic [MAX_CLASSES-1:0]       r_cls_vld;

    logic signed [SCORE_BITS-1:0] r_sc_rd;
    logic signed [SCORE_BITS-1:0] r_pend_rd;
    logic [CIX_W-1:0]             r_win_rd;
    t_cls                         r_cls_rd;
    logic                         r_cls_rd_vld;

    logic [CIX_W-1:0]             r_arg_best;
    logic signed [SUM_W-1:0]      r_arg_sum;
    logic [FRM_W-1:0]             r_top;

    logic                         r_out_vld;
    t_out_item                    r_out;

    logic [FRM_W-1:0]             w_eff;
    logic [SLOT_W:0]              w_slot_sum;
    logic [SLOT_W-1:0]            w_slot;
    logic [SLOT_W-1:0]            w_oldest_inc;
    logic [CIX_W-1:0]             w_cls_addr;
    logic signed [SUM_W-1:0]      w_cur_sum;
    logic [FRM_W-1:0]             w_cur_wins;
    logic [CLS_W-1:0]             w_c_next;
    logic [FRM_W+2:0]             w_top5;
    logic                         w_mismatch;
    logic                         w_out_free;

    always_comb begin
        if (r_win_size == '0) begin
            w_eff = FRM_W'(1);
        end else if (32'(r_win_size) > 32'(WINDOW_DEPTH)) begin
            w_eff = FRM_W'(WINDOW_DEPTH);
        end else begin
            w_eff = FRM_W'(r_win_size);
        end
    end

    assign w_slot_sum   = (SLOT_W+1)'(r_oldest) + (SLOT_W+1)'(r_frames);
    assign w_slot       = (w_slot_sum >= (SLOT_W+1)'(WINDOW_DEPTH))
                        ? SLOT_W'(w_slot_sum - (SLOT_W+1)'(WINDOW_DEPTH))
                        : SLOT_W'(w_slot_sum);
    assign w_oldest_inc = (r_oldest == SLOT_W'(WINDOW_DEPTH - 1))
                        ? '0 : r_oldest + SLOT_W'(1);
    assign w_cur_sum    = r_cls_rd_vld ? r_cls_rd.sum  : '0;
    assign w_cur_wins   = r_cls_rd_vld ? r_cls_rd.wins : '0;
    assign w_c_next     = CLS_W'(r_c) + CLS_W'(1);
    assign w_top5       = (FRM_W+3)'(r_top) + ((FRM_W+3)'(r_top) << 2);
    assign w_mismatch   = (r_frames != '0) && (r_ei != r_cpf);
    assign w_out_free   = !r_out_vld || !i_out_stall;

    always_comb begin
        case (i_op)
            OP_EW_RD2, OP_EW_WR: w_cls_addr = r_win_rd;
            OP_WIN_RD, OP_WIN_WR: w_cls_addr = r_best_cls;
            default:              w_cls_addr = r_c;
        endcase
    end

    assign o_status.need_evict = (r_frames >= w_eff);
    assign o_status.evict_last = (w_c_next == r_cpf);
    assign o_status.class_last = (w_c_next == r_ei);
    assign o_status.out_free   = w_out_free;

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    // Memories: registered reads, single write per cycle.
    always_ff @(posedge i_clk) begin
        if (i_op == OP_TAKE && r_ei < CLS_W'(MAX_CLASSES)) begin
            m_pend[CIX_W'(r_ei)] <= i_in_item.score;
        end
        if (i_op == OP_ADD_RD) begin
            r_pend_rd <= m_pend[r_c];
        end
        if (i_op == OP_EV_RD) begin
            r_sc_rd <= m_score[{r_oldest, r_c}];
        end
        if (i_op == OP_ADD_WR) begin
            m_score[{w_slot, r_c}] <= r_pend_rd;
        end
        if (i_op == OP_EW_RD) begin
            r_win_rd <= m_winner[r_oldest];
        end
        if (i_op == OP_WIN_RD) begin
            m_winner[w_slot] <= r_best_cls;
        end
        r_cls_rd     <= m_cls[w_cls_addr];
        r_cls_rd_vld <= r_cls_vld[w_cls_addr];
        case (i_op)
            OP_EV_WR: begin
                m_cls[w_cls_addr] <= '{sum: w_cur_sum - SUM_W'(r_sc_rd), wins: w_cur_wins};
            end
            OP_EW_WR: begin
                m_cls[w_cls_addr] <= '{sum: w_cur_sum,
                    wins: (w_cur_wins != '0) ? w_cur_wins - FRM_W'(1) : w_cur_wins};
            end
            OP_ADD_WR: begin
                m_cls[w_cls_addr] <= '{sum: w_cur_sum + SUM_W'(r_pend_rd), wins: w_cur_wins};
            end
            OP_WIN_WR: begin
                m_cls[w_cls_addr] <= '{sum: w_cur_sum, wins: w_cur_wins + FRM_W'(1)};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_size   <= WINDOW_SIZE_RST;
            r_frames     <= '0;
            r_oldest     <= '0;
            r_cpf        <= '0;
            r_ei         <= '0;
            r_best_score <= {1'b1, {(SCORE_BITS-1){1'b0}}};
            r_best_cls   <= '0;
            r_ovf        <= 1'b0;
            r_c          <= '0;
            r_cls_vld    <= '0;
            r_out_vld    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_win_size <= i_cfg_data;
            end
            if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            case (i_op)
                OP_TAKE: begin
                    if (r_ei < CLS_W'(MAX_CLASSES)) begin
                        if (r_ei == '0 || i_in_item.score > r_best_score) begin
                            r_best_score <= i_in_item.score;
                            r_best_cls   <= CIX_W'(r_ei);
                        end
                        r_ei <= r_ei + CLS_W'(1);
                    end else begin
                        r_ovf <= 1'b1;
                    end
                end
                OP_CLEAR: begin
                    r_cls_vld    <= '0;
                    r_frames     <= '0;
                    r_oldest     <= '0;
                    r_cpf        <= '0;
                    r_ei         <= '0;
                    r_best_score <= {1'b1, {(SCORE_BITS-1){1'b0}}};
                    r_best_cls   <= '0;
                    r_ovf        <= 1'b0;
                end
                OP_CHECK: begin
                    r_c <= '0;
                    if (w_mismatch) begin
                        r_cls_vld <= '0;
                        r_frames  <= '0;
                        r_oldest  <= '0;
                        r_cpf     <= '0;
                    end
                end
                OP_EV_WR, OP_ADD_WR: begin
                    r_cls_vld[w_cls_addr] <= 1'b1;
                    r_c <= r_c + CIX_W'(1);
                end
                OP_EW_WR: begin
                    r_cls_vld[w_cls_addr] <= 1'b1;
                    r_oldest <= w_oldest_inc;
                    r_frames <= r_frames - FRM_W'(1);
                    r_c      <= '0;
                end
                OP_WIN_WR: begin
                    r_cls_vld[w_cls_addr] <= 1'b1;
                    r_frames <= r_frames + FRM_W'(1);
                    r_cpf    <= r_ei;
                    r_c      <= '0;
                end
                OP_ARG_WR: begin
                    r_c <= r_c + CIX_W'(1);
                end
                OP_OUT: begin
                    r_out_vld    <= 1'b1;
                    r_ei         <= '0;
                    r_best_score <= {1'b1, {(SCORE_BITS-1){1'b0}}};
                    r_best_cls   <= '0;
                    r_ovf        <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == OP_ARG_WR) begin
            if (r_c == '0) begin
                r_arg_best <= '0;
                r_arg_sum  <= w_cur_sum;
                r_top      <= w_cur_wins;
            end else begin
                if (w_cur_sum > r_arg_sum) begin
                    r_arg_best <= r_c;
                    r_arg_sum  <= w_cur_sum;
                end
                if (w_cur_wins > r_top) begin
                    r_top <= w_cur_wins;
                end
            end
        end
        if (i_op == OP_OUT) begin
            r_out.top_class        <= CLASS_OUT_W'(r_arg_best);
            r_out.unknown          <= (w_top5 < (FRM_W+3)'(r_frames));
            r_out.frames_held      <= FRAMES_OUT_W'(r_frames);
            r_out.too_many_classes <= r_ovf;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/sliding_window_class_score_fusion.sv
// ----------------------------------------------------------------------------
// Sliding-window class score fusion
// Fuses per-class scores over a window of recent frames and reports the
// class with the highest summed score at each frame end.
//
//   Port group   Direction  Handshake        Payload
//   in           input      valid / stall    t_in_item
//   out          output     valid / stall    t_out_item
//   cfg          input      valid / ready    window_size
//
// A score item that does not end a frame leaves the input free; a frame end
// stalls it while each evicted frame's classes are walked, then all classes
// twice (add, then argmax), through the single-port per-class sum memory.
// Reset is synchronous and active low; all window state is empty after it.
// The result register frees the input side; a stalled result only holds the
// next frame end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_class_score_fusion #(
    parameter int MAX_CLASSES  = swcsf_pkg::MAX_CLASSES_DEF,
    parameter int WINDOW_DEPTH = swcsf_pkg::WINDOW_DEPTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    input  wire swcsf_pkg::t_in_item         i_in_item,
    output logic                             o_in_stall,
    output logic                             o_out_valid,
    output swcsf_pkg::t_out_item             o_out_item,
    input  wire logic                        i_out_stall,
    input  wire logic                        i_cfg_valid,
    input  wire logic [swcsf_pkg::CFG_W-1:0] i_cfg_data,
    output logic                             o_cfg_ready
);
    import swcsf_pkg::*;

    t_op     w_op;
    t_status w_status;

    assign o_cfg_ready = 1'b1;

    swcsf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_op       (w_op)
    );

    swcsf_datapath #(
        .MAX_CLASSES  (MAX_CLASSES),
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_op        (w_op),
        .o_status    (w_status),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire
